// ===== hw/rtl/iocb_pkg.sv =====
package iocb_pkg;

  // bank geometry
  localparam int unsigned Channels = 8;
  localparam int unsigned Lanes    = (Channels < 8) ? Channels : 8;

  // field and register widths
  localparam int unsigned ChanW  = 3;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned CntW   = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 4;

  localparam logic [CntW-1:0] TimeoutReset = CntW'(1000);

  // register index, taken from paddr word bits
  typedef enum logic [1:0] {
    RegEnabled = 2'd0,
    RegPush    = 2'd1,
    RegTimeout = 2'd2
  } reg_idx_e;

  // item kind
  typedef enum logic {
    OpCommand = 1'b0,
    OpTick    = 1'b1
  } op_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [MaskW-1:0] enabled;
    logic [MaskW-1:0] push;
    logic [CntW-1:0]  timeout;
  } cfg_t;

  // one registered input item
  typedef struct packed {
    op_e              operation;
    logic [ChanW-1:0] channel;
    logic             press;
  } item_t;

endpackage

// ===== hw/rtl/iocb_cmd_if.sv =====
interface iocb_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [iocb_pkg::ChanW-1:0] channel;
  logic                      press;

  modport source (output valid, output operation, output channel, output press, input ready);
  modport sink (input valid, input operation, input channel, input press, output ready);
endinterface

// ===== hw/rtl/iocb_pin_if.sv =====
interface iocb_pin_if;
  logic                      valid;
  logic                      ready;
  logic [iocb_pkg::MaskW-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink (input valid, input pin_levels, output ready);
endinterface

// ===== hw/rtl/iocb_cfg_regs.sv =====
module iocb_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iocb_pkg::AddrW-1:0]  paddr,
  input  logic [iocb_pkg::DataW-1:0]  pwdata,
  output logic [iocb_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output iocb_pkg::cfg_t              cfg_o
);
  import iocb_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled <= '0;
      cfg_q.push    <= '0;
      cfg_q.timeout <= TimeoutReset;
    end else if (wr_en) begin
      unique case (idx)
        RegEnabled: cfg_q.enabled <= pwdata[MaskW-1:0];
        RegPush:    cfg_q.push    <= pwdata[MaskW-1:0];
        RegTimeout: cfg_q.timeout <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      RegEnabled: prdata = DataW'(cfg_q.enabled);
      RegPush:    prdata = DataW'(cfg_q.push);
      RegTimeout: prdata = DataW'(cfg_q.timeout);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/iocb_in_reg.sv =====
module iocb_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  iocb_cmd_if.sink        cmd_i,
  input  logic            take_i,
  output logic            valid_o,
  output iocb_pkg::item_t item_o
);
  import iocb_pkg::*;

  logic  valid_q;
  item_t item_q;

  // free when empty or when the held transaction moves on this cycle
  assign cmd_i.ready = ~valid_q | take_i;
  assign valid_o     = valid_q;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      valid_q <= cmd_i.valid;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      item_q.operation <= op_e'(cmd_i.operation);
      item_q.channel   <= cmd_i.channel;
      item_q.press     <= cmd_i.press;
    end
  end

endmodule

// ===== hw/rtl/iocb_bank_core.sv =====
module iocb_bank_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iocb_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  iocb_pkg::item_t item_i,
  output logic            take_o,
  iocb_pin_if.source      pin_o
);
  import iocb_pkg::*;

  logic [Lanes-1:0] level_q, level_d;
  logic [CntW-1:0]  cnt_q [Lanes];
  logic [CntW-1:0]  cnt_d [Lanes];
  logic [CntW-1:0]  cnt_inc [Lanes];
  logic [Lanes-1:0] live, push, sel;
  logic             tgt_live, tgt_push;
  logic             out_valid_q;
  logic [MaskW-1:0] pins_q;

  assign live = cfg_i.enabled[Lanes-1:0];
  assign push = cfg_i.push[Lanes-1:0];

  // result register frees up when empty or taken
  assign take_o = valid_i & (~out_valid_q | pin_o.ready);

  // per-lane decode of the addressed channel and saturating increment
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      sel[i]     = (item_i.channel == ChanW'(i));
      cnt_inc[i] = (cnt_q[i] == '1) ? cnt_q[i] : cnt_q[i] + CntW'(1);
    end
  end

  assign tgt_live = |(sel & live);
  assign tgt_push = |(sel & push);

  // next state for one transaction
  always_comb begin
    level_d = level_q;
    cnt_d   = cnt_q;
    if (take_o) begin
      if (item_i.operation == OpTick) begin
        for (int i = 0; i < Lanes; i++) begin
          if (live[i] && !push[i] && level_q[i] && (cnt_inc[i] >= cfg_i.timeout)) begin
            level_d[i] = 1'b0;
            cnt_d[i]   = '0;
          end else begin
            cnt_d[i]   = cnt_inc[i];
          end
        end
      end else if (tgt_live) begin
        for (int i = 0; i < Lanes; i++) begin
          if (tgt_push) begin
            if (sel[i]) begin
              level_d[i] = item_i.press;
              cnt_d[i]   = '0;
            end else if (item_i.press && live[i] && push[i]) begin
              // interlock: other enabled push channels drop
              level_d[i] = 1'b0;
              cnt_d[i]   = '0;
            end
          end else if (item_i.press && sel[i]) begin
            level_d[i] = ~level_q[i];
            cnt_d[i]   = '0;
          end
        end
      end
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      for (int i = 0; i < Lanes; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      level_q <= level_d;
      cnt_q   <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | pin_o.ready) begin
      out_valid_q <= take_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      pins_q <= MaskW'(level_d & live);
    end
  end

  assign pin_o.valid      = out_valid_q;
  assign pin_o.pin_levels = pins_q;

endmodule

// ===== hw/rtl/interlocked_output_channel_bank.sv =====
// Interlocked output channel bank.
// cmd_i carries one transaction per item: a command (channel, press or
// release) or a single time tick. pin_o returns one transaction per item
// with the pin levels of all channels after that item; disabled channels
// read 0. Push channels interlock: a press lowers every other enabled push
// channel. Toggle channels flip on press and drop after toggle_timeout
// ticks. Registers sit on an APB port: enabled_mask at 0x0, push_mask at
// 0x4, toggle_timeout at 0x8; write them only while the bank is idle.
// A result passes through the input register, which holds the item, and
// then the result register, into which the channel update is loaded.
// The bank takes one item per cycle while the receiver takes results;
// the level bits and the per-channel 32-bit saturating counters update
// as each item is taken.
// Reset clears all levels and counters, the masks to 0 and the timeout to
// 1000. When the receiver stalls, the result register holds its value and
// one more item waits in the input register; cmd_i.ready then drops.
module interlocked_output_channel_bank (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  iocb_cmd_if.sink                    cmd_i,
  iocb_pin_if.source                  pin_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iocb_pkg::AddrW-1:0]  paddr,
  input  logic [iocb_pkg::DataW-1:0]  pwdata,
  output logic [iocb_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import iocb_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  take;

  // configuration registers
  iocb_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  iocb_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  // channel state and result register
  iocb_bank_core u_bank_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (item_valid),
    .item_i  (item),
    .take_o  (take),
    .pin_o   (pin_o)
  );

endmodule

// ===== tb/sv/interlocked_output_channel_bank_tb.sv =====
module interlocked_output_channel_bank_tb;
  import iocb_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  iocb_cmd_if cmd_if ();
  iocb_pin_if pin_if ();

  interlocked_output_channel_bank dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .pin_o   (pin_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the bank: configuration, levels and tick counters
  cfg_t             bank_cfg;
  logic [MaskW-1:0] bank_levels;
  logic [CntW-1:0]  bank_elapsed [8];

  // pin levels still owed by the block, oldest first
  logic [MaskW-1:0] pins_due [$];

  int  fail_count;
  int  items_sent;
  int  pins_seen;
  int  cfg_writes;
  int  hold_left;
  int  stall_left;
  bit  idle_on;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("timeout: %0d pin transactions still owed", pins_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // next pin levels of the bank after one item
  function automatic logic [MaskW-1:0] advance_bank(input item_t it);
    logic [MaskW-1:0] live;
    live = '0;
    for (int i = 0; i < Lanes; i++) live[i] = 1'b1;
    live &= bank_cfg.enabled;
    if (it.operation == OpTick) begin
      for (int i = 0; i < Lanes; i++) begin
        if (bank_elapsed[i] != '1) bank_elapsed[i]++;
        if (live[i] && !bank_cfg.push[i] && bank_levels[i] &&
            bank_elapsed[i] >= bank_cfg.timeout) begin
          bank_levels[i]  = 1'b0;
          bank_elapsed[i] = '0;
        end
      end
    end else if (live[it.channel]) begin
      if (bank_cfg.push[it.channel]) begin
        if (it.press) begin
          // interlock: every other enabled push channel goes low
          for (int i = 0; i < Lanes; i++) begin
            if (live[i] && bank_cfg.push[i] && i != it.channel) begin
              bank_levels[i]  = 1'b0;
              bank_elapsed[i] = '0;
            end
          end
          bank_levels[it.channel] = 1'b1;
        end else begin
          bank_levels[it.channel] = 1'b0;
        end
        bank_elapsed[it.channel] = '0;
      end else if (it.press) begin
        bank_levels[it.channel]  = ~bank_levels[it.channel];
        bank_elapsed[it.channel] = '0;
      end
    end
    return bank_levels & live;
  endfunction

  // one command or tick transaction; called and returning at a rising edge
  task automatic send_item(input op_e op, input logic [ChanW-1:0] ch, input logic press);
    item_t it;
    int    gap;
    logic  taken;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.channel   <= ch;
    cmd_if.press     <= press;
    do begin
      @(negedge clk_i);
      taken = cmd_if.ready;
      @(posedge clk_i);
    end while (!taken);
    it.operation = op;
    it.channel   = ch;
    it.press     = press;
    pins_due.insert(pins_due.size(), advance_bank(it));
    items_sent++;
  endtask

  task automatic send_random_item();
    op_e op;
    op = ($urandom_range(0, 99) < 40) ? OpTick : OpCommand;
    send_item(op, ChanW'($urandom_range(0, 7)), ($urandom_range(0, 99) < 65));
  endtask

  // stop offering and wait until every owed transaction has arrived
  task automatic drain_bank();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pins_due.size() != 0);
  endtask

  // one APB transfer: setup phase, then access until pready
  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done  = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // program all registers; only called with the bank idle
  task automatic set_config(input logic [MaskW-1:0] en, input logic [MaskW-1:0] push,
                            input logic [CntW-1:0] tmo);
    logic [DataW-1:0] unused;
    apb_access(1'b1, RegEnabled, DataW'(en), unused);
    apb_access(1'b1, RegPush, DataW'(push), unused);
    apb_access(1'b1, RegTimeout, DataW'(tmo), unused);
    bank_cfg.enabled = en;
    bank_cfg.push    = push;
    bank_cfg.timeout = tmo;
    cfg_writes += 3;
  endtask

  // read back every register against the shadow copy
  task automatic check_registers();
    logic [DataW-1:0] rd;
    apb_access(1'b0, RegEnabled, '0, rd);
    if (rd !== DataW'(bank_cfg.enabled)) begin
      $error("enabled_mask mismatch: expected %h, actual %h", bank_cfg.enabled, rd);
      fail_count++;
    end
    apb_access(1'b0, RegPush, '0, rd);
    if (rd !== DataW'(bank_cfg.push)) begin
      $error("push_mask mismatch: expected %h, actual %h", bank_cfg.push, rd);
      fail_count++;
    end
    apb_access(1'b0, RegTimeout, '0, rd);
    if (rd !== DataW'(bank_cfg.timeout)) begin
      $error("toggle_timeout mismatch: expected %h, actual %h", bank_cfg.timeout, rd);
      fail_count++;
    end
  endtask

  // receiver: random stalls, long holds on request, compare each transaction
  initial begin : pin_monitor
    logic [MaskW-1:0] want;
    pin_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        pin_if.ready <= 1'b0;
        hold_left--;
      end else if (!idle_on) begin
        pin_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        pin_if.ready <= 1'b0;
        stall_left--;
      end else begin
        pin_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
      @(negedge clk_i);
      if (rst_ni && pin_if.valid === 1'b1 && pin_if.ready === 1'b1) begin
        pins_seen++;
        if (pins_due.size() == 0) begin
          $error("pin transaction with nothing owed: pin_levels %h", pin_if.pin_levels);
          fail_count++;
        end else begin
          want = pins_due.pop_front();
          if (pin_if.pin_levels !== want) begin
            $error("pin_levels mismatch: expected %h, actual %h", want, pin_if.pin_levels);
            fail_count++;
          end
        end
      end
    end
  end

  // reset values, and commands that a bank with no channels ignores
  task automatic test_reset_state();
    check_registers();
    send_item(OpCommand, 3'd0, 1'b1);
    send_item(OpTick, 3'd7, 1'b0);
    drain_bank();
  endtask

  // push interlock: a press lowers the other push channels
  task automatic test_push_interlock();
    set_config(8'hFF, 8'h0F, 32'd1000);
    check_registers();
    send_item(OpCommand, 3'd0, 1'b1);
    send_item(OpCommand, 3'd3, 1'b1);
    send_item(OpCommand, 3'd4, 1'b1);
    send_item(OpCommand, 3'd1, 1'b1);
    send_item(OpCommand, 3'd1, 1'b0);
    send_item(OpCommand, 3'd2, 1'b1);
    send_item(OpTick, 3'd0, 1'b0);
    drain_bank();
  endtask

  // toggle flip, ignored release, drop after the timeout
  task automatic test_toggle_timeout();
    set_config(8'hFF, 8'h00, 32'd1);
    send_item(OpCommand, 3'd5, 1'b1);
    send_item(OpTick, 3'd0, 1'b0);
    drain_bank();
    set_config(8'hFF, 8'h00, 32'd3);
    send_item(OpCommand, 3'd6, 1'b1);
    send_item(OpCommand, 3'd6, 1'b0);
    send_item(OpCommand, 3'd7, 1'b1);
    send_item(OpCommand, 3'd7, 1'b1);
    send_item(OpTick, 3'd0, 1'b0);
    send_item(OpTick, 3'd0, 1'b0);
    send_item(OpTick, 3'd0, 1'b0);
    drain_bank();
  endtask

  // disabled channel keeps its level hidden, it reappears when enabled
  task automatic test_disabled_channel();
    set_config(8'hFF, 8'h02, 32'hFFFF_FFFF);
    send_item(OpCommand, 3'd1, 1'b1);
    drain_bank();
    set_config(8'hFD, 8'h02, 32'hFFFF_FFFF);
    send_item(OpCommand, 3'd1, 1'b0);
    send_item(OpTick, 3'd0, 1'b0);
    drain_bank();
    set_config(8'hFF, 8'h02, 32'hFFFF_FFFF);
    send_item(OpTick, 3'd0, 1'b0);
    drain_bank();
  endtask

  // raised push channel turned into a toggle channel drops on timeout
  task automatic test_type_change();
    set_config(8'hFF, 8'h01, 32'd2);
    send_item(OpCommand, 3'd0, 1'b1);
    drain_bank();
    set_config(8'hFF, 8'h00, 32'd2);
    send_item(OpTick, 3'd0, 1'b0);
    send_item(OpTick, 3'd0, 1'b0);
    drain_bank();
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    set_config(8'hFF, 8'h33, 32'd4);
    idle_on   = 1'b0;
    hold_left = 300;
    repeat (40) send_random_item();
    drain_bank();
    idle_on = 1'b1;
  endtask

  // random traffic over a series of settings, extremes first
  task automatic test_random_traffic();
    logic [MaskW-1:0] en;
    logic [MaskW-1:0] push;
    logic [CntW-1:0]  tmo;
    int               sel;
    for (int phase = 0; phase < 10; phase++) begin
      en   = MaskW'($urandom_range(0, 255));
      push = MaskW'($urandom_range(0, 255));
      sel  = $urandom_range(0, 4);
      case (sel)
        0:       tmo = 32'd1;
        1:       tmo = $urandom_range(2, 8);
        2:       tmo = $urandom_range(9, 40);
        3:       tmo = $urandom() | 32'h1;
        default: tmo = 32'hFFFF_FFFF;
      endcase
      case (phase)
        0: begin en = 8'hFF; push = 8'hFF; tmo = 32'd1; end
        1: begin en = 8'hFF; push = 8'h00; tmo = 32'd1; end
        2: begin en = 8'h00; tmo = 32'hFFFF_FFFF; end
        3: begin en = 8'hFF; push = 8'h00; tmo = 32'hFFFF_FFFF; end
        default: ;
      endcase
      set_config(en, push, tmo);
      if (phase % 3 == 0) check_registers();
      idle_on = (phase % 4 != 2);
      repeat (150) send_random_item();
      drain_bank();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.operation = 1'b0;
    cmd_if.channel   = '0;
    cmd_if.press     = 1'b0;
    fail_count   = 0;
    items_sent   = 0;
    pins_seen    = 0;
    cfg_writes   = 0;
    hold_left    = 0;
    idle_on      = 1'b1;
    bank_cfg     = '{enabled: '0, push: '0, timeout: TimeoutReset};
    bank_levels  = '0;
    for (int i = 0; i < 8; i++) bank_elapsed[i] = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_push_interlock();
    test_toggle_timeout();
    test_disabled_channel();
    test_type_change();
    test_backpressure();
    test_random_traffic();

    // tail: let any stray transaction show up
    drain_bank();
    repeat (20) @(posedge clk_i);
    if (pins_due.size() != 0) begin
      $error("pin transactions never arrived: %0d", pins_due.size());
      fail_count++;
    end

    $display("run: %0d commands and ticks, %0d pin transactions, %0d register writes",
             items_sent, pins_seen, cfg_writes);
    $display("covered push interlock, toggle timeout, disabled and retyped channels, stalls");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== interlocked_output_channel_bank.f =====
hw/rtl/iocb_pkg.sv
hw/rtl/iocb_cmd_if.sv
hw/rtl/iocb_pin_if.sv
hw/rtl/iocb_cfg_regs.sv
hw/rtl/iocb_in_reg.sv
hw/rtl/iocb_bank_core.sv
hw/rtl/interlocked_output_channel_bank.sv
tb/sv/interlocked_output_channel_bank_tb.sv
